// ===== hw/rtl/cpu8a_pkg.sv =====
// Shared types and opcode constants for the 8-bit CPU arithmetic unit.
`default_nettype none
package cpu8a_pkg;

   localparam logic [3:0] OP_ADD8  = 4'd0;
   localparam logic [3:0] OP_ADC8  = 4'd1;
   localparam logic [3:0] OP_SUB8  = 4'd2;
   localparam logic [3:0] OP_SBC8  = 4'd3;
   localparam logic [3:0] OP_XOR8  = 4'd4;
   localparam logic [3:0] OP_INC8  = 4'd5;
   localparam logic [3:0] OP_DEC8  = 4'd6;
   localparam logic [3:0] OP_ADD16 = 4'd7;
   localparam logic [3:0] OP_SPOFF = 4'd8;
   localparam logic [3:0] OP_INC16 = 4'd9;
   localparam logic [3:0] OP_DEC16 = 4'd10;

   localparam int FLAG_Z = 3;
   localparam int FLAG_N = 2;
   localparam int FLAG_H = 1;
   localparam int FLAG_C = 0;

   typedef struct packed {
      logic [3:0]  opcode;
      logic [15:0] operand_a;
      logic [15:0] operand_b;
      logic [3:0]  flags_in;
   } req_type;

   typedef struct packed {
      logic [15:0] result;
      logic [3:0]  flags_out;
   } rsp_type;

   typedef enum logic [1:0] {
      RES_SUM8,
      RES_SUM16,
      RES_XOR,
      RES_ZERO
   } res_sel_type;

   typedef enum logic [2:0] {
      FL_ARITH8,
      FL_INCDEC8,
      FL_XOR,
      FL_ADD16,
      FL_SPOFF,
      FL_KEEP
   } flag_sel_type;

   typedef struct packed {
      res_sel_type  res_sel;
      flag_sel_type flag_sel;
      logic [15:0]  addend;
      logic         carry_in;
      logic         inv_carry;
      logic         n_flag;
   } ctl_type;

endpackage
`default_nettype wire

// ===== hw/rtl/cpu8_alu_with_flags_core.sv =====
// Top level: three-stage pipelined 8-bit CPU arithmetic unit with Z/N/H/C flags.
//
//   channel   ports                    direction  moves
//   request   start, busy, req_data    in         one operation per transaction
//   response  rsp_strobe, rsp_data     out        result and flags, one per transaction
//
// A transaction is taken on every cycle that start is high; busy is always low.
// The stages are the input register, the low-byte adder stage and the high-byte
// adder and flag stage; the 16-bit carry chain split across the two adder
// stages sets the cycle time. The response is shown for one cycle and cannot
// be stalled, so the pipeline never holds. Reset clears the valid bits only.
`default_nettype none
module cpu8_alu_with_flags_core (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 start,
   output logic                busy,
   input  wire cpu8a_pkg::req_type req_data,
   output logic                rsp_strobe,
   output cpu8a_pkg::rsp_type  rsp_data
);

   logic               s1_valid_ff;
   cpu8a_pkg::req_type s1_req_ff;

   cpu8a_pkg::ctl_type s1_ctl;
   logic [4:0]         s1_nib_sum;
   logic [4:0]         s1_top_sum;
   logic [7:0]         s1_xor;

   logic               s2_valid_ff;
   cpu8a_pkg::ctl_type s2_ctl_ff;
   logic [7:0]         s2_a_hi_ff;
   logic [7:0]         s2_sum_lo_ff;
   logic               s2_c4_ff;
   logic               s2_c8_ff;
   logic [7:0]         s2_xor_ff;
   logic [3:0]         s2_flags_ff;

   logic [4:0]         s2_mid_sum;
   logic [4:0]         s2_hi_sum;
   logic               s2_h;
   logic               s2_c;
   cpu8a_pkg::rsp_type rsp_in;

   logic               rsp_valid_ff;
   cpu8a_pkg::rsp_type rsp_ff;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start & ~busy;
      end
      s1_req_ff <= req_data;
   end

   cpu8a_decode u_decode (
      .req (s1_req_ff),
      .ctl (s1_ctl)
   );

   assign s1_nib_sum = {1'b0, s1_req_ff.operand_a[3:0]} + {1'b0, s1_ctl.addend[3:0]}
                       + {4'd0, s1_ctl.carry_in};
   assign s1_top_sum = {1'b0, s1_req_ff.operand_a[7:4]} + {1'b0, s1_ctl.addend[7:4]}
                       + {4'd0, s1_nib_sum[4]};
   assign s1_xor     = s1_req_ff.operand_a[7:0] ^ s1_req_ff.operand_b[7:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_ctl_ff    <= s1_ctl;
      s2_a_hi_ff   <= s1_req_ff.operand_a[15:8];
      s2_sum_lo_ff <= {s1_top_sum[3:0], s1_nib_sum[3:0]};
      s2_c4_ff     <= s1_nib_sum[4];
      s2_c8_ff     <= s1_top_sum[4];
      s2_xor_ff    <= s1_xor;
      s2_flags_ff  <= s1_req_ff.flags_in;
   end

   assign s2_mid_sum = {1'b0, s2_a_hi_ff[3:0]} + {1'b0, s2_ctl_ff.addend[11:8]}
                       + {4'd0, s2_c8_ff};
   assign s2_hi_sum  = {1'b0, s2_a_hi_ff[7:4]} + {1'b0, s2_ctl_ff.addend[15:12]}
                       + {4'd0, s2_mid_sum[4]};
   assign s2_h       = s2_c4_ff ^ s2_ctl_ff.inv_carry;
   assign s2_c       = s2_c8_ff ^ s2_ctl_ff.inv_carry;

   always_comb begin
      case (s2_ctl_ff.res_sel)
         cpu8a_pkg::RES_SUM8:  rsp_in.result = {8'h00, s2_sum_lo_ff};
         cpu8a_pkg::RES_SUM16: rsp_in.result = {s2_hi_sum[3:0], s2_mid_sum[3:0], s2_sum_lo_ff};
         cpu8a_pkg::RES_XOR:   rsp_in.result = {8'h00, s2_xor_ff};
         default:              rsp_in.result = 16'h0000;
      endcase
      case (s2_ctl_ff.flag_sel)
         cpu8a_pkg::FL_ARITH8: begin
            rsp_in.flags_out = {(s2_sum_lo_ff == 8'h00), s2_ctl_ff.n_flag, s2_h, s2_c};
         end
         cpu8a_pkg::FL_INCDEC8: begin
            rsp_in.flags_out = {(s2_sum_lo_ff == 8'h00), s2_ctl_ff.n_flag, s2_h,
                                s2_flags_ff[cpu8a_pkg::FLAG_C]};
         end
         cpu8a_pkg::FL_XOR: begin
            rsp_in.flags_out = {(s2_xor_ff == 8'h00), 3'b000};
         end
         cpu8a_pkg::FL_ADD16: begin
            rsp_in.flags_out = {s2_flags_ff[cpu8a_pkg::FLAG_Z], 1'b0, s2_mid_sum[4],
                                s2_hi_sum[4]};
         end
         cpu8a_pkg::FL_SPOFF: begin
            rsp_in.flags_out = {2'b00, s2_c4_ff, s2_c8_ff};
         end
         default: begin
            rsp_in.flags_out = s2_flags_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= s2_valid_ff;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   a_take: assert property (@(posedge clock) disable iff (reset)
      start |=> s1_valid_ff)
      else $error("accepted transaction not captured");

   a_advance: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |=> rsp_valid_ff)
      else $error("transaction lost in last stage");

   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      !s2_valid_ff |=> !rsp_valid_ff)
      else $error("response strobe without transaction");

   a_byte_result: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && (s2_ctl_ff.res_sel == cpu8a_pkg::RES_SUM8 ||
                      s2_ctl_ff.res_sel == cpu8a_pkg::RES_XOR)
      |=> rsp_ff.result[15:8] == 8'h00)
      else $error("8-bit result with nonzero high byte");

   a_keep_flags: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && s2_ctl_ff.flag_sel == cpu8a_pkg::FL_KEEP
      |=> rsp_ff.flags_out == $past(s2_flags_ff))
      else $error("flags changed on flag-preserving operation");

endmodule
`default_nettype wire

// ===== hw/rtl/cpu8a_decode.sv =====
// Opcode decode: adder operand, carry in and result/flag selection.
`default_nettype none
module cpu8a_decode (
   input  wire cpu8a_pkg::req_type req,
   output cpu8a_pkg::ctl_type      ctl
);

   logic [7:0] b_lo;
   logic       c_flag;

   assign b_lo   = req.operand_b[7:0];
   assign c_flag = req.flags_in[cpu8a_pkg::FLAG_C];

   always_comb begin
      ctl.res_sel   = cpu8a_pkg::RES_ZERO;
      ctl.flag_sel  = cpu8a_pkg::FL_KEEP;
      ctl.addend    = 16'h0000;
      ctl.carry_in  = 1'b0;
      ctl.inv_carry = 1'b0;
      ctl.n_flag    = 1'b0;
      case (req.opcode)
         cpu8a_pkg::OP_ADD8: begin
            ctl.res_sel  = cpu8a_pkg::RES_SUM8;
            ctl.flag_sel = cpu8a_pkg::FL_ARITH8;
            ctl.addend   = {8'h00, b_lo};
         end
         cpu8a_pkg::OP_ADC8: begin
            ctl.res_sel  = cpu8a_pkg::RES_SUM8;
            ctl.flag_sel = cpu8a_pkg::FL_ARITH8;
            ctl.addend   = {8'h00, b_lo};
            ctl.carry_in = c_flag;
         end
         cpu8a_pkg::OP_SUB8: begin
            ctl.res_sel   = cpu8a_pkg::RES_SUM8;
            ctl.flag_sel  = cpu8a_pkg::FL_ARITH8;
            ctl.addend    = {8'h00, ~b_lo};
            ctl.carry_in  = 1'b1;
            ctl.inv_carry = 1'b1;
            ctl.n_flag    = 1'b1;
         end
         cpu8a_pkg::OP_SBC8: begin
            ctl.res_sel   = cpu8a_pkg::RES_SUM8;
            ctl.flag_sel  = cpu8a_pkg::FL_ARITH8;
            ctl.addend    = {8'h00, ~b_lo};
            ctl.carry_in  = ~c_flag;
            ctl.inv_carry = 1'b1;
            ctl.n_flag    = 1'b1;
         end
         cpu8a_pkg::OP_XOR8: begin
            ctl.res_sel  = cpu8a_pkg::RES_XOR;
            ctl.flag_sel = cpu8a_pkg::FL_XOR;
         end
         cpu8a_pkg::OP_INC8: begin
            ctl.res_sel  = cpu8a_pkg::RES_SUM8;
            ctl.flag_sel = cpu8a_pkg::FL_INCDEC8;
            ctl.carry_in = 1'b1;
         end
         cpu8a_pkg::OP_DEC8: begin
            ctl.res_sel   = cpu8a_pkg::RES_SUM8;
            ctl.flag_sel  = cpu8a_pkg::FL_INCDEC8;
            ctl.addend    = 16'h00FF;
            ctl.inv_carry = 1'b1;
            ctl.n_flag    = 1'b1;
         end
         cpu8a_pkg::OP_ADD16: begin
            ctl.res_sel  = cpu8a_pkg::RES_SUM16;
            ctl.flag_sel = cpu8a_pkg::FL_ADD16;
            ctl.addend   = req.operand_b;
         end
         cpu8a_pkg::OP_SPOFF: begin
            ctl.res_sel  = cpu8a_pkg::RES_SUM16;
            ctl.flag_sel = cpu8a_pkg::FL_SPOFF;
            ctl.addend   = {{8{b_lo[7]}}, b_lo};
         end
         cpu8a_pkg::OP_INC16: begin
            ctl.res_sel  = cpu8a_pkg::RES_SUM16;
            ctl.carry_in = 1'b1;
         end
         cpu8a_pkg::OP_DEC16: begin
            ctl.res_sel = cpu8a_pkg::RES_SUM16;
            ctl.addend  = 16'hFFFF;
         end
         default: begin
            ctl.res_sel  = cpu8a_pkg::RES_ZERO;
            ctl.flag_sel = cpu8a_pkg::FL_KEEP;
         end
      endcase
   end

endmodule
`default_nettype wire
